FILE: src/tas_pkg.sv
// ============================================================================
// tas_pkg
// Shared constants for the timed actuation scheduler.
// ============================================================================
package tas_pkg;

    localparam int TAS_NUM_ACTUATORS = 8;
    localparam int TAS_QUEUE_DEPTH   = 16;
    localparam int TIME_W            = 62;
    localparam int NSEC_W            = 30;
    localparam int SEC_W             = 32;
    localparam int CYC_W             = 26;
    localparam int CFG_W             = 4;
    localparam int OP_SCHEDULE       = 0;
    localparam int OP_EXPIRE         = 1;
    localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);
    localparam int CYCLE_NS          = 20;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

endpackage

FILE: src/timed_actuation_scheduler_core.sv
// ============================================================================
// timed_actuation_scheduler_core
// Per-actuator deadline ring queues in one memory, one armed deadline, and
// the wait from the current time to each newly armed deadline.
// ============================================================================
// channel  | dir | tdata (low bit up)                                 | tuser
// s_axis   | in  | actuator_id[2:0] due_sec[34:3] due_nsec[64:35]      | op
//          |     | now_sec[96:65] now_nsec[126:97], pad to 128         |
// m_axis   | out | fire[0] fire_actuator[3:1] timer_armed[4]           | -
//          |     | armed_actuator[7:5] load_timer[8] wait_sec[40:9]    |
//          |     | wait_cycles[66:41] overflow[67], pad to 72          |
// cfg      | in  | cfg_data = actuators_in_use                         | -
// A schedule, or an expiry while idle, passes S_SCHED, S_W0, S_W1, S_W2 and
// S_OUT; an expiry that scans also walks S_SCAN and S_SCANW for each queue in
// use, one head at a time through the single read port of the queue memory,
// then S_POP. The wait divide by 20 is a reciprocal multiply, registered in S_W1.
// Reset is immediate: queue entries are guarded by their counts.
// A result waits in the output register; the next item is taken only after
// the result transfer, so output stalls hold the whole block.
module timed_actuation_scheduler_core #(
    parameter int NUM_ACTUATORS = tas_pkg::TAS_NUM_ACTUATORS,
    parameter int QUEUE_DEPTH   = tas_pkg::TAS_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // actuator_id, due_sec, due_nsec, now_sec, now_nsec
    input  logic         s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // fire, fire_actuator, timer_armed, armed_actuator,
                                         // load_timer, wait_sec, wait_cycles, overflow
    input  logic         cfg_we,
    input  logic [3:0]   cfg_data
);
    import tas_pkg::*;

    localparam int AW  = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = AW + QW;
    localparam int NCW = $clog2(NUM_ACTUATORS + 1);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCHED = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_SCANW = 4'd3;
    localparam logic [3:0] S_POP = 4'd4;
    localparam logic [3:0] S_W0 = 4'd5;
    localparam logic [3:0] S_W1 = 4'd6;
    localparam logic [3:0] S_W2 = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;

    logic [TIME_W-1:0] mem [2**MW];
    logic              mem_we;
    logic [MW-1:0]     mem_waddr, mem_raddr;
    logic [TIME_W-1:0] mem_wdata, mem_rdata_reg;

    logic [QW-1:0] head_reg [NUM_ACTUATORS];
    logic [QW-1:0] tail_reg [NUM_ACTUATORS];
    logic [CW-1:0] cnt_reg  [NUM_ACTUATORS];

    logic [3:0]        state_reg;
    logic [CFG_W-1:0]  cfg_reg;
    logic              run_valid_reg;
    logic [AW-1:0]     run_owner_reg;
    logic [TIME_W-1:0] armed_reg;

    logic              op_reg;
    logic [2:0]        id_reg;
    logic [TIME_W-1:0] due_reg, now_reg;
    logic              fire_reg, load_reg, ovf_reg;
    logic [2:0]        fire_act_reg;

    logic [NCW-1:0]    scan_reg, scan_n;
    logic [AW-1:0]     rd_idx_reg;
    logic              found_reg;
    logic [AW-1:0]     best_reg;
    logic [TIME_W-1:0] best_t_reg;

    logic              miss_reg;
    logic [SEC_W-1:0]  ws_reg;
    logic [NSEC_W-1:0] wn_reg;
    logic [63:0]       prod_reg;
    logic [71:0]       out_reg;
    logic              out_valid_reg;

    logic [SEC_W-1:0]  ds, ns;
    logic [NSEC_W-1:0] dn, nn;
    logic [NSEC_W:0]   diff_n;
    logic [CYC_W-1:0]  wc;

    logic              id_ok;
    logic [AW-1:0]     id_idx;
    logic [QW-1:0]     own_head_dec, id_tail_inc, best_head_inc;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        if ({28'd0, cfg_reg} > NUM_ACTUATORS)
            scan_n = NCW'(NUM_ACTUATORS);
        else
            scan_n = NCW'(cfg_reg);
        id_ok  = ({29'd0, id_reg} < NUM_ACTUATORS);
        id_idx = AW'(id_reg);
        own_head_dec  = (head_reg[run_owner_reg] == '0) ? QW'(QUEUE_DEPTH - 1)
                                                        : head_reg[run_owner_reg] - QW'(1);
        id_tail_inc   = (tail_reg[id_idx] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : tail_reg[id_idx] + QW'(1);
        best_head_inc = (head_reg[best_reg] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_reg[best_reg] + QW'(1);
        ds = armed_reg[TIME_W-1:NSEC_W];
        dn = armed_reg[NSEC_W-1:0];
        ns = now_reg[TIME_W-1:NSEC_W];
        nn = now_reg[NSEC_W-1:0];
        if (dn >= nn)
            diff_n = {1'b0, dn - nn};
        else
            diff_n = {1'b0, dn} + {1'b0, NS_PER_SEC} - {1'b0, nn};
        // x/20 = (x>>2)/5, (x>>2) < 2^29: multiply by ceil(2^33/5)
        wc = CYC_W'(prod_reg >> 33);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = due_reg;
        mem_raddr = {rd_idx_reg, head_reg[rd_idx_reg]};
        if (state_reg == S_SCHED && op_reg == 1'(OP_SCHEDULE) && id_ok && run_valid_reg) begin
            if (armed_reg > due_reg) begin
                mem_we    = (cnt_reg[run_owner_reg] < CW'(QUEUE_DEPTH));
                mem_waddr = {run_owner_reg, own_head_dec};
                mem_wdata = armed_reg;
            end else begin
                mem_we    = (cnt_reg[id_idx] < CW'(QUEUE_DEPTH));
                mem_waddr = {id_idx, tail_reg[id_idx]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cfg_reg       <= CFG_RESET;
            run_valid_reg <= 1'b0;
            run_owner_reg <= '0;
            armed_reg     <= TIME_MAX;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ACTUATORS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we)
                cfg_reg <= cfg_data;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        op_reg   <= s_axis_tuser;
                        id_reg   <= s_axis_tdata[2:0];
                        due_reg  <= {s_axis_tdata[34:3], s_axis_tdata[64:35]};
                        now_reg  <= {s_axis_tdata[96:65], s_axis_tdata[126:97]};
                        fire_reg <= 1'b0;
                        fire_act_reg <= 3'd0;
                        load_reg <= 1'b0;
                        ovf_reg  <= 1'b0;
                        state_reg <= S_SCHED;
                    end
                end
                S_SCHED:
                begin
                    if (op_reg == 1'(OP_SCHEDULE)) begin
                        state_reg <= S_W0;
                        if (id_ok) begin
                            if (!run_valid_reg) begin
                                run_valid_reg <= 1'b1;
                                run_owner_reg <= id_idx;
                                armed_reg     <= due_reg;
                                load_reg      <= 1'b1;
                            end else if (armed_reg > due_reg) begin
                                if (cnt_reg[run_owner_reg] >= CW'(QUEUE_DEPTH))
                                    ovf_reg <= 1'b1;
                                else begin
                                    head_reg[run_owner_reg] <= own_head_dec;
                                    cnt_reg[run_owner_reg]  <= cnt_reg[run_owner_reg] + CW'(1);
                                end
                                run_owner_reg <= id_idx;
                                armed_reg     <= due_reg;
                                load_reg      <= 1'b1;
                            end else if (cnt_reg[id_idx] >= CW'(QUEUE_DEPTH))
                                ovf_reg <= 1'b1;
                            else begin
                                tail_reg[id_idx] <= id_tail_inc;
                                cnt_reg[id_idx]  <= cnt_reg[id_idx] + CW'(1);
                            end
                        end
                    end else if (run_valid_reg) begin
                        fire_reg     <= 1'b1;
                        fire_act_reg <= 3'(run_owner_reg);
                        scan_reg     <= '0;
                        rd_idx_reg   <= '0;
                        found_reg    <= 1'b0;
                        state_reg    <= S_SCAN;
                    end else
                        state_reg <= S_W0;
                end
                S_SCAN:
                begin
                    if (scan_reg >= scan_n)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_SCANW;
                end
                S_SCANW:
                begin
                    if (cnt_reg[rd_idx_reg] != '0 &&
                        (!found_reg || mem_rdata_reg < best_t_reg)) begin
                        found_reg  <= 1'b1;
                        best_t_reg <= mem_rdata_reg;
                        best_reg   <= rd_idx_reg;
                    end
                    scan_reg   <= scan_reg + NCW'(1);
                    rd_idx_reg <= AW'(scan_reg + NCW'(1));
                    state_reg  <= S_SCAN;
                end
                S_POP:
                begin
                    if (found_reg) begin
                        head_reg[best_reg] <= best_head_inc;
                        cnt_reg[best_reg]  <= cnt_reg[best_reg] - CW'(1);
                        run_owner_reg      <= best_reg;
                        armed_reg          <= best_t_reg;
                        load_reg           <= 1'b1;
                    end else begin
                        run_valid_reg <= 1'b0;
                        run_owner_reg <= '0;
                        armed_reg     <= TIME_MAX;
                    end
                    state_reg <= S_W0;
                end
                S_W0:
                begin
                    miss_reg <= armed_reg < now_reg;
                    ws_reg   <= ds - ns - SEC_W'(dn < nn);
                    wn_reg   <= diff_n[NSEC_W-1:0];
                    state_reg <= S_W1;
                end
                S_W1:
                begin
                    prod_reg  <= {36'd0, wn_reg[NSEC_W-1:2]} * 64'd1717986919;
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    out_reg <= {4'd0, ovf_reg,
                                (load_reg && !miss_reg) ? wc : CYC_W'(0),
                                (load_reg && !miss_reg) ? ws_reg : SEC_W'(0),
                                load_reg,
                                run_valid_reg ? 3'(run_owner_reg) : 3'd0,
                                run_valid_reg, fire_act_reg, fire_reg};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_idle_max: assert property (@(posedge clk) disable iff (!rst_n)
        !run_valid_reg |-> (armed_reg == TIME_MAX))
        else $error("idle timer with deadline");
`endif

endmodule
